// ----- rtl/sos_pkg.sv -----
package sos_pkg;

    // Configuration port
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STACKS   = 4'd1;
    localparam logic [CFG_W-1:0]     CFG_RST      = 5'd16;

    // Fixed field widths
    localparam int CMD_W = 2;
    localparam int IDX_W = 4;
    localparam int OC_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_POP_AT = 2'd2,
        CMD_PEEK   = 2'd3
    } sos_cmd_t;

    typedef enum logic [OC_W-1:0] {
        OC_DONE  = 2'd0,
        OC_EMPTY = 2'd1,
        OC_FULL  = 2'd2
    } sos_outcome_t;

    // Status derived from the occupancy bitmaps
    typedef struct packed {
        logic walk_hit;
        logic set_empty;
        logic set_full;
    } sos_flags_t;

    // Clamp a register write to 1..hi
    function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v, input int hi);
        logic [CFG_W-1:0] r;
        r = v;
        if (r == '0) begin
            r = CFG_W'(1);
        end
        if (int'(r) > hi) begin
            r = CFG_W'(hi);
        end
        return r;
    endfunction

endpackage

// ----- rtl/set_of_stacks_with_pop_at_unit.sv -----
// Set of stacks with pop-at. Substacks of stack_capacity elements share one element
// memory; commands are push, pop, pop from a named substack and peek, each giving
// exactly one result with the value read, an outcome code (done, target empty, push
// with no room left), set-empty and set-full flags and the current substack.
// Fill counts live in a second memory, shadowed by non-empty and full bitmaps that a
// combinational priority encoder walks back over. One item is worked at a time: a
// rejected command goes from acceptance to ST_FINISH, a push through ST_COUNT and
// ST_FINISH, and a pop, pop-at or peek through ST_COUNT, ST_FETCH and ST_FINISH, as
// the count memory read and the element memory read come in series; ST_FINISH waits
// for a free output register. A result may wait in the output register while
// the next command is accepted. A write to stack_capacity starts a refresh of the
// full bitmap over every substack, during which s_tready stays low. Register writes
// beyond the two defined indices are ignored; out-of-range values are clamped.
module set_of_stacks_with_pop_at_unit import sos_pkg::*; #(
    parameter int MAX_STACK_DEPTH = 16,
    parameter int MAX_STACKS      = 16,
    parameter int DATA_WIDTH      = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // command [1:0], push_value [DATA_WIDTH+1:2], substack_index [DATA_WIDTH+5:DATA_WIDTH+2]
    input  logic [((CMD_W + DATA_WIDTH + IDX_W + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // read_value [DATA_WIDTH-1:0], outcome, set_is_empty, set_is_full, current_stack
    output logic [((DATA_WIDTH + OC_W + 2 + IDX_W + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int M_W    = ((DATA_WIDTH + OC_W + 2 + IDX_W + 7) / 8) * 8;
    localparam int PTR_W  = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int CNT_W  = $clog2(MAX_STACK_DEPTH + 1);
    localparam int ELEMS  = MAX_STACKS * MAX_STACK_DEPTH;
    localparam int EA_W   = (ELEMS > 1) ? $clog2(ELEMS) : 1;
    localparam int CW_A   = (PTR_W + 1 > CFG_W) ? PTR_W + 1 : CFG_W;
    localparam int CW_B   = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
    localparam int CW     = (CW_A > CW_B) ? CW_A : CW_B;

    localparam logic [CFG_W-1:0] CAP_RST = clamp_cfg(CFG_RST, MAX_STACK_DEPTH);
    localparam logic [CFG_W-1:0] SIU_RST = clamp_cfg(CFG_RST, MAX_STACKS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_FETCH,
        ST_FINISH,
        ST_SWEEP
    } state_t;

    state_t                  state_reg;
    logic [CFG_W-1:0]        cap_reg;
    logic [CFG_W-1:0]        siu_reg;
    logic [PTR_W-1:0]        ptr_reg;
    logic [MAX_STACKS-1:0]   ne_reg;
    logic [MAX_STACKS-1:0]   full_reg;
    logic                    sweep_req_reg;
    logic [PTR_W:0]          sw_cnt_reg;

    // Per-command working registers
    sos_cmd_t                cmd_reg;
    logic [DATA_WIDTH-1:0]   val_reg;
    logic [PTR_W-1:0]        tgt_reg;
    sos_outcome_t            oc_reg;
    logic [DATA_WIDTH-1:0]   rd_reg;

    // Output register
    logic                    m_valid_reg;
    logic [DATA_WIDTH-1:0]   out_rd_reg;
    sos_outcome_t            out_oc_reg;
    logic                    out_empty_reg;
    logic                    out_full_reg;
    logic [IDX_W-1:0]        out_cur_reg;

    // Input fields
    sos_cmd_t                in_cmd;
    logic [DATA_WIDTH-1:0]   in_val;
    logic [IDX_W-1:0]        in_idx;

    logic                    cap_write;
    logic                    siu_write;
    logic                    accept;
    logic                    out_free;

    logic [PTR_W-1:0]        walk_idx;
    sos_flags_t              flags;

    // Accept-cycle decode
    logic [CW-1:0]           push_t;
    logic [PTR_W-1:0]        push_t_idx;
    logic                    push_t_full;
    logic                    push_ok;
    logic                    popat_ok;
    logic                    cmd_ok;
    logic [PTR_W-1:0]        dec_tgt;
    logic [PTR_W-1:0]        dec_ptr;
    sos_outcome_t            dec_oc;

    // Count memory
    logic                    cnt_we;
    logic [PTR_W-1:0]        cnt_raddr;
    logic [CNT_W-1:0]        cnt_q;
    logic [CNT_W-1:0]        cnt_cur;
    logic [CNT_W-1:0]        cnt_new;
    logic [PTR_W-1:0]        sw_wr_idx;

    // Element memory
    logic                    elem_we;
    logic [EA_W-1:0]         elem_addr;
    logic [DATA_WIDTH-1:0]   elem_q;

    assign in_cmd = sos_cmd_t'(s_tdata[CMD_W-1:0]);
    assign in_val = s_tdata[CMD_W +: DATA_WIDTH];
    assign in_idx = s_tdata[CMD_W + DATA_WIDTH +: IDX_W];

    assign cap_write = cfg_valid && (cfg_index == REG_CAPACITY);
    assign siu_write = cfg_valid && (cfg_index == REG_STACKS);
    assign cfg_ready = 1'b1;

    // Accept commands only in ST_IDLE, and hold them off while the full bitmap is stale
    assign s_tready = (state_reg == ST_IDLE) && !sweep_req_reg && !cap_write;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    sos_pick #(
        .MAX_STACKS (MAX_STACKS),
        .PTR_W      (PTR_W)
    ) u_pick (
        .nonempty      (ne_reg),
        .full          (full_reg),
        .ptr           (ptr_reg),
        .stacks_in_use (siu_reg),
        .walk_idx      (walk_idx),
        .flags         (flags)
    );

    // Decide the target substack and outcome from the bitmaps, without reading the counts
    always_comb begin
        push_t      = CW'(ptr_reg) + CW'(full_reg[ptr_reg]);
        push_t_idx  = push_t[PTR_W-1:0];
        push_t_full = (int'(push_t) < MAX_STACKS) ? full_reg[push_t_idx] : 1'b1;
        push_ok     = (push_t < CW'(siu_reg)) && (int'(push_t) < MAX_STACKS) && !push_t_full;
        popat_ok    = (CW'(in_idx) < CW'(siu_reg)) && (int'(in_idx) < MAX_STACKS)
                      && ne_reg[in_idx[PTR_W-1:0]];
        cmd_ok      = 1'b0;
        dec_tgt     = ptr_reg;
        dec_ptr     = ptr_reg;
        dec_oc      = OC_DONE;
        case (in_cmd)
            CMD_PUSH: begin
                cmd_ok  = push_ok;
                dec_tgt = push_t_idx;
                dec_ptr = push_ok ? push_t_idx : ptr_reg;
                dec_oc  = push_ok ? OC_DONE : OC_FULL;
            end
            CMD_POP_AT: begin
                cmd_ok  = popat_ok;
                dec_tgt = in_idx[PTR_W-1:0];
                dec_oc  = popat_ok ? OC_DONE : OC_EMPTY;
            end
            CMD_POP, CMD_PEEK: begin
                cmd_ok  = flags.walk_hit;
                dec_tgt = walk_idx;
                dec_ptr = walk_idx;
                dec_oc  = flags.walk_hit ? OC_DONE : OC_EMPTY;
            end
            default: begin
                cmd_ok = 1'b0;
            end
        endcase
    end

    // Count memory: read at the target on acceptance, written back in ST_COUNT unless peek
    assign cnt_raddr = (state_reg == ST_SWEEP) ? sw_cnt_reg[PTR_W-1:0] : dec_tgt;
    assign cnt_cur   = ne_reg[tgt_reg] ? cnt_q : '0;
    assign cnt_new   = (cmd_reg == CMD_PUSH) ? cnt_cur + CNT_W'(1) : cnt_cur - CNT_W'(1);
    assign cnt_we    = (state_reg == ST_COUNT) && (cmd_reg != CMD_PEEK);
    assign sw_wr_idx = PTR_W'(sw_cnt_reg - (PTR_W + 1)'(1));

    sos_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_STACKS)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (cnt_we),
        .wr_addr (tgt_reg),
        .wr_data (cnt_new),
        .rd_addr (cnt_raddr),
        .rd_data (cnt_q)
    );

    // Element memory: push writes at the fill count, pop, pop-at and peek read one below
    assign elem_we   = (state_reg == ST_COUNT) && (cmd_reg == CMD_PUSH);
    assign elem_addr = EA_W'(32'(tgt_reg) * MAX_STACK_DEPTH
                       + 32'((cmd_reg == CMD_PUSH) ? cnt_cur : cnt_cur - CNT_W'(1)));

    sos_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (ELEMS)
    ) u_elem_ram (
        .aclk    (aclk),
        .wr_en   (elem_we),
        .wr_addr (elem_addr),
        .wr_data (val_reg),
        .rd_addr (elem_addr),
        .rd_data (elem_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RST;
            siu_reg       <= SIU_RST;
            ptr_reg       <= '0;
            ne_reg        <= '0;
            full_reg      <= '0;
            sweep_req_reg <= 1'b0;
            sw_cnt_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // Register writes
            if (cap_write) begin
                cap_reg <= clamp_cfg(cfg_data, MAX_STACK_DEPTH);
            end
            if (siu_write) begin
                siu_reg <= clamp_cfg(cfg_data, MAX_STACKS);
            end

            // Drop the result once taken, unless a new one replaces it
            if (m_valid_reg && m_tready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (cap_write || sweep_req_reg) begin
                        state_reg     <= ST_SWEEP;
                        sweep_req_reg <= 1'b0;
                        sw_cnt_reg    <= '0;
                    end else if (accept) begin
                        cmd_reg   <= in_cmd;
                        val_reg   <= in_val;
                        tgt_reg   <= dec_tgt;
                        oc_reg    <= dec_oc;
                        rd_reg    <= '0;
                        ptr_reg   <= dec_ptr;
                        state_reg <= cmd_ok ? ST_COUNT : ST_FINISH;
                    end
                end
                ST_COUNT: begin
                    if (cmd_reg != CMD_PEEK) begin
                        ne_reg[tgt_reg]   <= (cnt_new != '0);
                        full_reg[tgt_reg] <= (CW'(cnt_new) >= CW'(cap_reg));
                    end
                    state_reg <= (cmd_reg == CMD_PUSH) ? ST_FINISH : ST_FETCH;
                    if (cap_write) begin
                        sweep_req_reg <= 1'b1;
                    end
                end
                ST_FETCH: begin
                    rd_reg    <= elem_q;
                    state_reg <= ST_FINISH;
                    if (cap_write) begin
                        sweep_req_reg <= 1'b1;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        out_rd_reg    <= rd_reg;
                        out_oc_reg    <= oc_reg;
                        out_empty_reg <= flags.set_empty;
                        out_full_reg  <= flags.set_full;
                        out_cur_reg   <= IDX_W'(ptr_reg);
                        state_reg     <= ST_IDLE;
                    end
                    if (cap_write) begin
                        sweep_req_reg <= 1'b1;
                    end
                end
                ST_SWEEP: begin
                    // Refresh one full bit a cycle from the count read last cycle
                    if (sw_cnt_reg != '0) begin
                        full_reg[sw_wr_idx] <= ne_reg[sw_wr_idx]
                                               && (CW'(cnt_q) >= CW'(cap_reg));
                    end
                    if (cap_write) begin
                        sw_cnt_reg <= '0;
                    end else if (int'(sw_cnt_reg) == MAX_STACKS) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        sw_cnt_reg <= sw_cnt_reg + (PTR_W + 1)'(1);
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_W'({out_cur_reg, out_full_reg, out_empty_reg, out_oc_reg, out_rd_reg});

endmodule

// ----- rtl/sos_ram.sv -----
module sos_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/sos_pick.sv -----
module sos_pick import sos_pkg::*; #(
    parameter int MAX_STACKS = 16,
    parameter int PTR_W      = 4
) (
    input  logic [MAX_STACKS-1:0] nonempty,
    input  logic [MAX_STACKS-1:0] full,
    input  logic [PTR_W-1:0]      ptr,
    input  logic [CFG_W-1:0]      stacks_in_use,
    output logic [PTR_W-1:0]      walk_idx,
    output sos_flags_t            flags
);

    // Highest non-empty substack at or below the pointer, zero when none; also the set-empty and set-full flags
    always_comb begin
        logic hit;
        logic [PTR_W-1:0] idx;
        logic all_full;
        hit      = 1'b0;
        idx      = '0;
        all_full = 1'b1;
        for (int i = 0; i < MAX_STACKS; i++) begin
            if (i <= int'(ptr) && nonempty[i]) begin
                hit = 1'b1;
                idx = PTR_W'(i);
            end
            if (i < int'(stacks_in_use) && !full[i]) begin
                all_full = 1'b0;
            end
        end
        walk_idx        = idx;
        flags.walk_hit  = hit;
        flags.set_empty = ~|nonempty;
        flags.set_full  = all_full;
    end

endmodule

// ----- rtl/sos_check.sv -----
module sos_check import sos_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [((DATA_WIDTH + OC_W + 2 + IDX_W + 7) / 8) * 8 - 1:0] m_tdata,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index
);

    logic [DATA_WIDTH-1:0] read_value;
    logic [OC_W-1:0]       outcome;
    logic                  set_is_empty;
    logic                  set_is_full;

    assign read_value   = m_tdata[DATA_WIDTH-1:0];
    assign outcome      = m_tdata[DATA_WIDTH +: OC_W];
    assign set_is_empty = m_tdata[DATA_WIDTH + OC_W];
    assign set_is_full  = m_tdata[DATA_WIDTH + OC_W + 1];

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Rejected commands return no value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (outcome != OC_DONE) |-> read_value == '0)
        else $error("rejected command returned a value");

    // A full set always holds an element
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(set_is_empty && set_is_full))
        else $error("set reported both empty and full");

    // A capacity write blocks commands while the full bitmap is refreshed
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready && (cfg_index == REG_CAPACITY) |=> !s_tready)
        else $error("command accepted right after a capacity write");

endmodule

bind set_of_stacks_with_pop_at_unit sos_check #(
    .DATA_WIDTH (DATA_WIDTH)
) u_sos_check (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index)
);

// ----- dv/set_of_stacks_with_pop_at_unit_tb.sv -----
`timescale 1ns / 100ps

module set_of_stacks_with_pop_at_unit_tb;
    import sos_pkg::*;

    // Geometry of the instance (the block's parameter defaults)
    localparam int STACK_DEPTH = 16;
    localparam int STACK_COUNT = 16;
    localparam int DATA_W      = 32;
    localparam int S_W         = ((CMD_W + DATA_W + IDX_W + 7) / 8) * 8;
    localparam int M_W         = ((DATA_W + OC_W + 2 + IDX_W + 7) / 8) * 8;

    // Register index outside the defined pair; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd15;

    localparam int RESET_CYCLES = 6;
    localparam int IDLE_PCT     = 35;
    localparam int HOLD_CYCLES  = 300;
    localparam int END_SETTLE   = 20;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 94;
    localparam int CYCLE_LIMIT  = 400000;

    // One command transaction: command in the low bits, as on s_tdata
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] value;
        sos_cmd_t          cmd;
    } stack_cmd_t;

    // One reply transaction: read value in the low bits, as on m_tdata
    typedef struct packed {
        logic [IDX_W-1:0]  cur;
        logic              full;
        logic              empty;
        sos_outcome_t      oc;
        logic [DATA_W-1:0] rd;
    } stack_reply_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic [S_W-1:0]       s_tdata   = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [M_W-1:0]       m_tdata;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    set_of_stacks_with_pop_at_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),   // command, push_value, substack_index
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),   // read_value, outcome, set_is_empty, set_is_full, current_stack
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow state of the set: element memory, per-substack fill counts,
    // current pointer and the two clamped register values
    logic [DATA_W-1:0] stack_mem [0:STACK_COUNT*STACK_DEPTH-1];
    logic [4:0]        fill_count [0:STACK_COUNT-1];
    logic [IDX_W-1:0]  cur_ptr;
    logic [CFG_W-1:0]  cap_per_stack;
    logic [CFG_W-1:0]  stacks_active;

    stack_cmd_t   command_backlog[$];    // commands waiting for the driver
    stack_reply_t predicted_replies[$];  // replies owed by the block, oldest first

    int  err_cnt      = 0;
    int  cycle_cnt    = 0;
    int  settings_cnt = 1;
    int  cmd_count [4];
    int  oc_count  [3];
    int  full_seen    = 0;
    bit  in_fire      = 1'b0;
    bit  no_gaps      = 1'b0;
    int  hold_reqs    = 0;
    int  hold_served  = 0;
    int  hold_left    = 0;

    // Apply one command to the shadow state and return the reply it owes
    function automatic stack_reply_t run_stack_command(stack_cmd_t c);
        stack_reply_t r;
        int           t;
        bit           found;
        r       = '0;
        r.oc    = OC_DONE;
        found   = 1'b0;
        // pop and peek first walk the pointer back over empty substacks
        if (c.cmd == CMD_POP || c.cmd == CMD_PEEK) begin
            while (cur_ptr != 0 && fill_count[cur_ptr] == 0)
                cur_ptr = cur_ptr - 1'b1;
            found = (fill_count[cur_ptr] != 0);
        end
        case (c.cmd)
            CMD_PUSH: begin
                t = int'(cur_ptr);
                if (fill_count[t] >= cap_per_stack)
                    t++;
                // no room to move on: reject and leave everything as it is
                if (t >= int'(stacks_active) || t >= STACK_COUNT
                        || fill_count[t] >= cap_per_stack) begin
                    r.oc = OC_FULL;
                end else begin
                    cur_ptr = IDX_W'(t);
                    stack_mem[t*STACK_DEPTH + int'(fill_count[t])] = c.value;
                    fill_count[t] = fill_count[t] + 5'd1;
                end
            end
            CMD_POP: begin
                if (found) begin
                    fill_count[cur_ptr] = fill_count[cur_ptr] - 5'd1;
                    r.rd = stack_mem[int'(cur_ptr)*STACK_DEPTH + int'(fill_count[cur_ptr])];
                end else begin
                    r.oc = OC_EMPTY;
                end
            end
            CMD_POP_AT: begin
                // the hole left behind is not compacted
                if (c.idx < stacks_active && fill_count[c.idx] != 0) begin
                    fill_count[c.idx] = fill_count[c.idx] - 5'd1;
                    r.rd = stack_mem[int'(c.idx)*STACK_DEPTH + int'(fill_count[c.idx])];
                end else begin
                    r.oc = OC_EMPTY;
                end
            end
            default: begin
                if (found)
                    r.rd = stack_mem[int'(cur_ptr)*STACK_DEPTH
                                     + int'(fill_count[cur_ptr]) - 1];
                else
                    r.oc = OC_EMPTY;
            end
        endcase
        r.empty = 1'b1;
        for (t = 0; t < STACK_COUNT; t++)
            if (fill_count[t] != 0)
                r.empty = 1'b0;
        // a substack at or over capacity counts as full, even past a shrink
        r.full = 1'b1;
        for (t = 0; t < int'(stacks_active) && t < STACK_COUNT; t++)
            if (fill_count[t] < cap_per_stack)
                r.full = 1'b0;
        r.cur = cur_ptr;
        return r;
    endfunction

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            err_cnt++;
            $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got);
        end
    endtask

    // Monitor: sample every handshake at the rising edge, advance the shadow
    // state on accepted commands and register writes, check accepted replies
    always @(posedge aclk) begin
        stack_reply_t want;
        stack_reply_t got;
        logic [CFG_W-1:0] clamped;
        cycle_cnt++;
        if (!aresetn) begin
            for (int i = 0; i < STACK_COUNT; i++)
                fill_count[i] = '0;
            cur_ptr       = '0;
            cap_per_stack = CFG_RST;
            stacks_active = CFG_RST;
            in_fire       = 1'b0;
        end else begin
            in_fire = s_tvalid && s_tready;
            if (cfg_valid && cfg_ready) begin
                clamped = (cfg_data == '0) ? CFG_W'(1) : cfg_data;
                if (cfg_index == REG_CAPACITY)
                    cap_per_stack = (clamped > STACK_DEPTH) ? CFG_W'(STACK_DEPTH) : clamped;
                else if (cfg_index == REG_STACKS)
                    stacks_active = (clamped > STACK_COUNT) ? CFG_W'(STACK_COUNT) : clamped;
            end
            if (in_fire) begin
                want = run_stack_command(stack_cmd_t'(s_tdata[$bits(stack_cmd_t)-1:0]));
                predicted_replies.push_back(want);
                cmd_count[s_tdata[CMD_W-1:0]]++;
                oc_count[want.oc]++;
                if (want.full)
                    full_seen++;
            end
            if (m_tvalid && m_tready) begin
                got = stack_reply_t'(m_tdata);
                if (predicted_replies.size() == 0) begin
                    err_cnt++;
                    $error("reply transaction with nothing outstanding: m_tdata 0x%0h", m_tdata);
                end else begin
                    want = predicted_replies.pop_front();
                    check_field("read_value",    want.rd,    got.rd);
                    check_field("outcome",       want.oc,    got.oc);
                    check_field("set_is_empty",  want.empty, got.empty);
                    check_field("set_is_full",   want.full,  got.full);
                    check_field("current_stack", want.cur,   got.cur);
                end
            end
        end
    end

    // Driver: offer the next command once the current transaction has gone,
    // idling at random unless the gap-free stretch is on
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || in_fire)) begin
            if (command_backlog.size() != 0
                    && (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_tdata  <= S_W'(command_backlog.pop_front());
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Sink: random back-pressure, plus a long hold-off whenever one is asked for
    always @(negedge aclk) begin
        if (hold_reqs != hold_served) begin
            hold_served = hold_reqs;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d replies outstanding",
                 cycle_cnt, predicted_replies.size());
        $display("set_of_stacks_with_pop_at_unit_tb NOT OK");
        $finish;
    end

    function automatic stack_cmd_t make_cmd(sos_cmd_t c, logic [DATA_W-1:0] v,
                                            logic [IDX_W-1:0] i);
        stack_cmd_t s;
        s.cmd   = c;
        s.value = v;
        s.idx   = i;
        return s;
    endfunction

    // Register values lean to the extremes, including ones that get clamped
    function automatic logic [CFG_W-1:0] pick_setting();
        case ($urandom_range(0, 5))
            0:       return CFG_W'(0);
            1:       return CFG_W'(1);
            2:       return CFG_W'(16);
            3:       return CFG_W'(31);
            default: return CFG_W'($urandom_range(2, 6));
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every command has gone in and every reply has come back
    task automatic wait_drained();
        do @(posedge aclk);
        while (command_backlog.size() != 0 || s_tvalid || predicted_replies.size() != 0);
    endtask

    // Queue one phase of random commands; push_pct steers towards filling
    // or draining so that full and empty sets both get reached
    task automatic queue_random_phase(int n, int push_pct);
        sos_cmd_t          c;
        logic [DATA_W-1:0] v;
        logic [IDX_W-1:0]  i;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < push_pct)
                c = CMD_PUSH;
            else if ($urandom_range(0, 2) == 0)
                c = CMD_POP;
            else if ($urandom_range(0, 1) == 0)
                c = CMD_POP_AT;
            else
                c = CMD_PEEK;
            case ($urandom_range(0, 7))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7fff_ffff;
                2:       v = '0;
                3:       v = '1;
                default: v = $urandom;
            endcase
            // mostly address substacks in use, sometimes any index
            if ($urandom_range(0, 9) < 7)
                i = IDX_W'($urandom_range(0, int'(stacks_active) - 1));
            else
                i = IDX_W'($urandom_range(0, STACK_COUNT - 1));
            command_backlog.push_back(make_cmd(c, v, i));
        end
    endtask

    initial begin
        int push_pct;
        foreach (cmd_count[k]) cmd_count[k] = 0;
        foreach (oc_count[k])  oc_count[k]  = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty set under the reset settings, then data extremes in and out
        command_backlog.push_back(make_cmd(CMD_PEEK,   32'h1234_5678, 4'd0));
        command_backlog.push_back(make_cmd(CMD_POP,    32'h0,         4'd0));
        command_backlog.push_back(make_cmd(CMD_POP_AT, 32'h0,         4'd0));
        command_backlog.push_back(make_cmd(CMD_POP_AT, 32'hffff_ffff, 4'd15));
        command_backlog.push_back(make_cmd(CMD_PUSH,   32'h7fff_ffff, 4'd15));
        command_backlog.push_back(make_cmd(CMD_PUSH,   32'h8000_0000, 4'd0));
        command_backlog.push_back(make_cmd(CMD_PUSH,   32'hffff_ffff, 4'd7));
        command_backlog.push_back(make_cmd(CMD_PUSH,   32'h0,         4'd8));
        command_backlog.push_back(make_cmd(CMD_PEEK,   32'h0,         4'd0));
        command_backlog.push_back(make_cmd(CMD_POP_AT, 32'h0,         4'd0));
        command_backlog.push_back(make_cmd(CMD_POP,    32'h0,         4'd0));
        command_backlog.push_back(make_cmd(CMD_POP,    32'h0,         4'd0));
        command_backlog.push_back(make_cmd(CMD_POP,    32'h0,         4'd0));
        command_backlog.push_back(make_cmd(CMD_POP,    32'h0,         4'd0));
        wait_drained();

        // Smallest capacity (zero clamps to one) across two substacks:
        // spill into the next substack, reject on the last, pop-at past the
        // substacks in use, leave a hole, and walk back to the first
        write_reg(REG_CAPACITY, CFG_W'(0));
        write_reg(REG_STACKS,   CFG_W'(2));
        settings_cnt++;
        command_backlog.push_back(make_cmd(CMD_PUSH,   32'h0000_00a1, 4'd0));
        command_backlog.push_back(make_cmd(CMD_PUSH,   32'h0000_00b2, 4'd0));
        command_backlog.push_back(make_cmd(CMD_PUSH,   32'h0000_00c3, 4'd0));
        command_backlog.push_back(make_cmd(CMD_POP_AT, 32'h0,         4'd5));
        command_backlog.push_back(make_cmd(CMD_POP_AT, 32'h0,         4'd0));
        command_backlog.push_back(make_cmd(CMD_PEEK,   32'h0,         4'd0));
        command_backlog.push_back(make_cmd(CMD_POP,    32'h0,         4'd0));
        command_backlog.push_back(make_cmd(CMD_POP,    32'h0,         4'd0));
        wait_drained();

        // Oversized values clamp to the maximum; the unused index changes nothing
        write_reg(REG_CAPACITY, CFG_W'(31));
        write_reg(REG_STACKS,   CFG_W'(31));
        write_reg(REG_UNUSED,   CFG_W'(3));

        for (int ph = 0; ph < PHASES; ph++) begin
            // Settings change only with the block drained; state carries over,
            // so shrinks leave counts over capacity and pointers past the end
            if (ph == 0) begin
                write_reg(REG_CAPACITY, CFG_W'(4));
                write_reg(REG_STACKS,   CFG_W'(4));
                push_pct = 70;
            end else if (ph == 1) begin
                write_reg(REG_CAPACITY, CFG_W'(2));
                write_reg(REG_STACKS,   CFG_W'(3));
                push_pct = 45;
            end else begin
                if ($urandom_range(0, 9) < 7)
                    write_reg(REG_CAPACITY, pick_setting());
                if ($urandom_range(0, 9) < 7)
                    write_reg(REG_STACKS, pick_setting());
                if ($urandom_range(0, 9) == 0)
                    write_reg(CFG_IDX_W'($urandom_range(int'(REG_STACKS) + 1,
                                                        int'(REG_UNUSED))),
                              pick_setting());
                case ($urandom_range(0, 2))
                    0:       push_pct = 70;
                    1:       push_pct = 45;
                    default: push_pct = 25;
                endcase
            end
            settings_cnt++;
            no_gaps = (ph == 6);
            queue_random_phase(PHASE_ITEMS, push_pct);
            // long receiver stall while the sender keeps offering commands
            if (ph == 4)
                hold_reqs++;
            wait_drained();
        end
        no_gaps = 1'b0;

        repeat (END_SETTLE) @(posedge aclk);

        $display("covered %0d commands: %0d push, %0d pop, %0d pop-at, %0d peek, %0d settings",
                 cmd_count[CMD_PUSH] + cmd_count[CMD_POP] + cmd_count[CMD_POP_AT]
                 + cmd_count[CMD_PEEK], cmd_count[CMD_PUSH], cmd_count[CMD_POP],
                 cmd_count[CMD_POP_AT], cmd_count[CMD_PEEK], settings_cnt);
        $display("outcomes: %0d done, %0d target empty, %0d push rejected; full set %0d times",
                 oc_count[OC_DONE], oc_count[OC_EMPTY], oc_count[OC_FULL], full_seen);
        if (err_cnt == 0) begin
            $display("set_of_stacks_with_pop_at_unit_tb OK");
        end else begin
            $display("set_of_stacks_with_pop_at_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
